// ===== rtl/vsd_pkg.sv =====
// Shared types and constants for the virtual segment decoder.
// No dependencies; imported by vsd_decode and virtual_segment_decoder.
`timescale 1ns / 1ps

package vsd_pkg;

   localparam int unsigned PHYS_ADDR_BITS_DEFAULT = 36;
   localparam int unsigned VADDR_BITS             = 64;

   localparam logic [VADDR_BITS-1:0] SEG_MASK_RESET = 64'h0000_00FF_FFFF_FFFF;

   // privilege mode codes; the unused code decodes as kernel
   localparam logic [1:0] MODE_KERNEL = 2'd0;
   localparam logic [1:0] MODE_SUPER  = 2'd1;
   localparam logic [1:0] MODE_USER   = 2'd2;

   // status flag bit positions
   localparam int unsigned FLAG_ERL = 0;
   localparam int unsigned FLAG_UX  = 1;
   localparam int unsigned FLAG_SX  = 2;
   localparam int unsigned FLAG_KX  = 3;

   // top two address bits select the extended region
   localparam logic [1:0] REGION_XUSEG  = 2'b00;
   localparam logic [1:0] REGION_XSSEG  = 2'b01;
   localparam logic [1:0] REGION_XKPHYS = 2'b10;
   localparam logic [1:0] REGION_XKSEG  = 2'b11;

   // bits 30:29 select the 512 MB window inside the top 2 GB
   localparam logic [1:0] WIN_KSEG0 = 2'b00;
   localparam logic [1:0] WIN_KSEG1 = 2'b01;
   localparam logic [1:0] WIN_SSEG  = 2'b10;
   localparam logic [1:0] WIN_KSEG3 = 2'b11;

   typedef enum logic [1:0] {
      OUT_DIRECT = 2'd0,
      OUT_LOOKUP = 2'd1,
      OUT_BAD    = 2'd2
   } outcome_type;

   typedef struct packed {
      logic erl;
      logic ux;
      logic sx;
      logic kx;
      logic kernel;
      logic super_ok;   // kernel or supervisor
   } priv_flags_type;

endpackage

// ===== rtl/vsd_decode.sv =====
// Segment decode: sorts one registered address into its segment and forms
// the outcome and physical address. Depends on vsd_pkg.
`timescale 1ns / 1ps

module vsd_decode
   import vsd_pkg::*;
#(
   parameter int unsigned PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEFAULT
) (
   input  logic [VADDR_BITS-1:0]     vaddr,
   input  priv_flags_type            acc,
   input  logic [VADDR_BITS-1:0]     seg_mask,
   output outcome_type               outcome,
   output logic [PHYS_ADDR_BITS-1:0] phys_addr
);

   logic        in_useg;
   logic        in_top2g;
   logic        xseg_fits;   // offset within the implemented extended size
   logic        xkphys_fits;
   outcome_type outc;
   logic [PHYS_ADDR_BITS-1:0] pa;

   assign in_useg     = (vaddr[63:31] == '0);
   assign in_top2g    = (vaddr[63:31] == '1);
   assign xseg_fits   = (vaddr[61:0] <= seg_mask[61:0]);
   assign xkphys_fits = (vaddr[58:PHYS_ADDR_BITS] == '0);

   always_comb begin
      outc = OUT_BAD;
      pa   = '0;
      if (in_useg) begin
         if (acc.erl) begin
            outc     = OUT_DIRECT;
            pa[31:0] = vaddr[31:0];
         end else begin
            outc = OUT_LOOKUP;
         end
      end else if (in_top2g) begin
         case (vaddr[30:29])
            WIN_KSEG0, WIN_KSEG1: begin
               if (acc.kernel) begin
                  outc     = OUT_DIRECT;
                  pa[28:0] = vaddr[28:0];
               end
            end
            WIN_SSEG: begin
               if (acc.super_ok) outc = OUT_LOOKUP;
            end
            default: begin
               if (acc.kernel) outc = OUT_LOOKUP;
            end
         endcase
      end else begin
         case (vaddr[63:62])
            REGION_XUSEG: begin
               if (acc.ux && xseg_fits) outc = OUT_LOOKUP;
            end
            REGION_XSSEG: begin
               if (acc.super_ok && acc.sx && xseg_fits) outc = OUT_LOOKUP;
            end
            REGION_XKPHYS: begin
               if (acc.kernel && acc.kx && xkphys_fits) begin
                  outc = OUT_DIRECT;
                  pa   = vaddr[PHYS_ADDR_BITS-1:0];
               end
            end
            default: begin
               if (acc.kernel && acc.kx && xseg_fits) outc = OUT_LOOKUP;
            end
         endcase
      end
   end

   assign outcome   = outc;
   assign phys_addr = pa;

endmodule

// ===== rtl/virtual_segment_decoder.sv =====
// Virtual segment decoder: each transfer carries a 64-bit virtual address,
// the privilege mode and status flags; the result tells whether the address
// is direct mapped (with its physical address and read/write grant), needs a
// translation lookup, or is bad. The block takes one address every cycle while
// the result is not stalled. The decode runs while the item sits in the input
// register, and its outcome is then captured in the result register, from
// which it transfers; a stalled result holds both stages.
// The segment mask is written through csr_wr_en/csr_wr_data and should only
// change while idle.
// Depends on vsd_pkg and vsd_decode.
`timescale 1ns / 1ps

module virtual_segment_decoder
   import vsd_pkg::*;
#(
   parameter int unsigned PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_wr_en,
   input  logic [VADDR_BITS-1:0]     csr_wr_data,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [VADDR_BITS-1:0]     req_virtual_address,
   input  logic [1:0]                req_privilege_mode,
   input  logic [3:0]                req_status_flags,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_outcome,
   output logic [PHYS_ADDR_BITS-1:0] rsp_physical_address,
   output logic                      rsp_read_write_allowed
);

   logic [VADDR_BITS-1:0] seg_mask_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic [VADDR_BITS-1:0] s1_vaddr_ff;
   priv_flags_type        s1_acc_ff, s1_acc_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   outcome_type               rsp_outcome_ff;
   logic [PHYS_ADDR_BITS-1:0] rsp_pa_ff;

   outcome_type               dec_outcome;
   logic [PHYS_ADDR_BITS-1:0] dec_pa;

   logic rsp_ld;
   logic s1_ld;
   logic req_xfer;

   // each stage loads when empty or when its contents move on
   assign rsp_ld   = !rsp_valid_ff || !rsp_stall;
   assign s1_ld    = !s1_valid_ff || rsp_ld;
   assign req_stall = !s1_ld;
   assign req_xfer = req_valid && s1_ld;

   always_comb begin
      s1_acc_in.erl      = req_status_flags[FLAG_ERL];
      s1_acc_in.ux       = req_status_flags[FLAG_UX];
      s1_acc_in.sx       = req_status_flags[FLAG_SX];
      s1_acc_in.kx       = req_status_flags[FLAG_KX];
      s1_acc_in.kernel   = (req_privilege_mode != MODE_USER) &&
                           (req_privilege_mode != MODE_SUPER);
      s1_acc_in.super_ok = (req_privilege_mode != MODE_USER);
   end

   assign s1_valid_in  = s1_ld ? req_valid : s1_valid_ff;
   assign rsp_valid_in = rsp_ld ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_mask_ff  <= SEG_MASK_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) seg_mask_ff <= csr_wr_data;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_vaddr_ff <= req_virtual_address;
         s1_acc_ff   <= s1_acc_in;
      end
      if (rsp_ld && s1_valid_ff) begin
         rsp_outcome_ff <= dec_outcome;
         rsp_pa_ff      <= dec_pa;
      end
   end

   vsd_decode #(
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) u_decode (
      .vaddr     (s1_vaddr_ff),
      .acc       (s1_acc_ff),
      .seg_mask  (seg_mask_ff),
      .outcome   (dec_outcome),
      .phys_addr (dec_pa)
   );

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_outcome            = rsp_outcome_ff;
   assign rsp_physical_address   = rsp_pa_ff;
   assign rsp_read_write_allowed = (rsp_outcome_ff == OUT_DIRECT);

   a_req_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("accepted request did not reach input stage");

   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_ld |=> rsp_valid_ff)
      else $error("input stage item lost before result register");

   a_pa_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_outcome_ff != OUT_DIRECT) |-> (rsp_pa_ff == '0))
      else $error("physical address set on a non-direct result");

   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("request taken while both stages are held");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for virtual_segment_decoder: directed and random
// address transfers, checked field by field by a scoreboard class.
// Depends on vsd_pkg and the virtual_segment_decoder RTL.
`timescale 1ns / 1ps

module tb_top;
   import vsd_pkg::*;

   localparam int unsigned PA_BITS  = PHYS_ADDR_BITS_DEFAULT;
   localparam int          WATCHDOG = 1000;
   localparam int          MAX_GAP  = 40;

   localparam logic [63:0] LOW62    = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LOW59    = 64'h07FF_FFFF_FFFF_FFFF;
   localparam logic [63:0] PA_LIMIT = (64'd1 << PA_BITS) - 64'd1;

   // unused mode code, decodes as kernel
   localparam logic [1:0] MODE_ALT_KERNEL = 2'd3;

   localparam logic [3:0] F_NONE = 4'b0000;
   localparam logic [3:0] F_ERL  = 4'b0001 << FLAG_ERL;
   localparam logic [3:0] F_UX   = 4'b0001 << FLAG_UX;
   localparam logic [3:0] F_SX   = 4'b0001 << FLAG_SX;
   localparam logic [3:0] F_KX   = 4'b0001 << FLAG_KX;
   localparam logic [3:0] F_X64  = F_UX | F_SX | F_KX;

   typedef struct packed {
      outcome_type          outcome;
      logic [PA_BITS-1:0]   phys;
      logic                 rw;
   } decode_result_type;

   class decode_scoreboard;
      decode_result_type expected_decodes[$];
      logic [63:0]       seg_mask;
      int                errors;

      function new();
         seg_mask = SEG_MASK_RESET;
         errors   = 0;
      endfunction

      function decode_result_type predict_decode(logic [63:0] va, logic [1:0] mode,
                                                 logic [3:0] flags);
         decode_result_type res;
         logic [63:0]    phys;
         logic           kern;
         logic           sup_ok;
         kern   = (mode != MODE_SUPER) && (mode != MODE_USER);
         sup_ok = kern || (mode == MODE_SUPER);
         res.outcome = OUT_BAD;
         phys = '0;
         if (va <= 64'h0000_0000_7FFF_FFFF) begin
            if (flags[FLAG_ERL]) begin
               res.outcome = OUT_DIRECT;
               phys = va & 64'hFFFF_FFFF;
            end else begin
               res.outcome = OUT_LOOKUP;
            end
         end else if (va < 64'h4000_0000_0000_0000) begin
            if (flags[FLAG_UX] && va <= (LOW62 & seg_mask))
               res.outcome = OUT_LOOKUP;
         end else if (va < 64'h8000_0000_0000_0000) begin
            if (sup_ok && flags[FLAG_SX] && (va & LOW62) <= (seg_mask & LOW62))
               res.outcome = OUT_LOOKUP;
         end else if (va < 64'hC000_0000_0000_0000) begin
            // bits 61..59 are ignored in xkphys
            if (kern && flags[FLAG_KX] && (va & LOW59) <= PA_LIMIT) begin
               res.outcome = OUT_DIRECT;
               phys = va & PA_LIMIT;
            end
         end else if (va < 64'hFFFF_FFFF_8000_0000) begin
            if (kern && flags[FLAG_KX] && (va & LOW62) <= (seg_mask & LOW62))
               res.outcome = OUT_LOOKUP;
         end else if (va < 64'hFFFF_FFFF_A000_0000) begin
            if (kern) begin
               res.outcome = OUT_DIRECT;
               phys = va - 64'hFFFF_FFFF_8000_0000;
            end
         end else if (va < 64'hFFFF_FFFF_C000_0000) begin
            if (kern) begin
               res.outcome = OUT_DIRECT;
               phys = va - 64'hFFFF_FFFF_A000_0000;
            end
         end else if (va < 64'hFFFF_FFFF_E000_0000) begin
            if (sup_ok)
               res.outcome = OUT_LOOKUP;
         end else begin
            if (kern)
               res.outcome = OUT_LOOKUP;
         end
         res.rw   = (res.outcome == OUT_DIRECT);
         res.phys = res.rw ? phys[PA_BITS-1:0] : '0;
         return res;
      endfunction

      function void note_request(logic [63:0] va, logic [1:0] mode, logic [3:0] flags);
         expected_decodes.push_back(predict_decode(va, mode, flags));
      endfunction

      function void check_result(logic [1:0] outcome, logic [PA_BITS-1:0] phys,
                                 logic rw);
         decode_result_type exp_res;
         if (expected_decodes.size() == 0) begin
            $display("%0t: result with nothing expected: outcome %0d phys %h rw %b",
                     $time, outcome, phys, rw);
            errors++;
            return;
         end
         exp_res = expected_decodes.pop_front();
         if (outcome !== exp_res.outcome) begin
            $display("%0t: outcome expected %0d actual %0d", $time, exp_res.outcome,
                     outcome);
            errors++;
         end
         if (phys !== exp_res.phys) begin
            $display("%0t: physical_address expected %h actual %h", $time,
                     exp_res.phys, phys);
            errors++;
         end
         if (rw !== exp_res.rw) begin
            $display("%0t: read_write_allowed expected %b actual %b", $time,
                     exp_res.rw, rw);
            errors++;
         end
      endfunction

      function int pending();
         return expected_decodes.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [63:0]         csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [63:0]         req_virtual_address = '0;
   logic [1:0]          req_privilege_mode = '0;
   logic [3:0]          req_status_flags = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_outcome;
   logic [PA_BITS-1:0]  rsp_physical_address;
   logic                rsp_read_write_allowed;

   decode_scoreboard sb = new();
   int idle_pct  = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   virtual_segment_decoder i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_virtual_address    (req_virtual_address),
      .req_privilege_mode     (req_privilege_mode),
      .req_status_flags       (req_status_flags),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_outcome            (rsp_outcome),
      .rsp_physical_address   (rsp_physical_address),
      .rsp_read_write_allowed (rsp_read_write_allowed)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // result checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_outcome, rsp_physical_address, rsp_read_write_allowed);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
            $display("virtual_segment_decoder: mismatch");
            $finish;
         end
      end
   end

   // called at a clock edge; returns at the edge that accepts the transfer
   task automatic send_item(logic [63:0] va, logic [1:0] mode, logic [3:0] flags);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_virtual_address <= va;
      req_privilege_mode  <= mode;
      req_status_flags    <= flags;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_request(va, mode, flags);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_seg_mask(logic [63:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.seg_mask = value;
   endtask

   task automatic random_item(output logic [63:0] va, output logic [1:0] mode,
                              output logic [3:0] flags);
      logic [63:0] r;
      logic [63:0] off;
      logic [63:0] pa_off;
      r = {$urandom, $urandom};
      case ($urandom_range(3))
         0: off = r & sb.seg_mask;
         1: off = sb.seg_mask - 64'd2 + 64'($urandom_range(4));
         2: off = r;
         default: off = r & 64'hFFFF;
      endcase
      case ($urandom_range(2))
         0: pa_off = r & PA_LIMIT;
         1: pa_off = PA_LIMIT - 64'd1 + 64'($urandom_range(2));
         default: pa_off = r;
      endcase
      if ($urandom_range(3) == 0)
         r[28:0] = {29{r[63]}};
      case ($urandom_range(11))
         0, 1:    va = {33'h0, r[30:0]};
         2:       va = {2'b00, off[61:0]};
         3:       va = {2'b01, off[61:0]};
         4:       va = {2'b10, r[61:59], pa_off[58:0]};
         5:       va = {2'b11, off[61:0]};
         6, 7, 8, 9, 10: va = {32'hFFFF_FFFF, r[31:29], r[28:0]};
         default: va = r;
      endcase
      case ($urandom_range(9))
         0, 1, 2, 3, 4: mode = MODE_KERNEL;
         5, 6:          mode = MODE_SUPER;
         7, 8:          mode = MODE_USER;
         default:       mode = MODE_ALT_KERNEL;
      endcase
      flags = 4'($urandom_range(15));
      if ($urandom_range(9) < 6)
         flags = flags | F_X64;
   endtask

   task automatic run_phase(logic [63:0] mask, int idle, int stall, int count,
                            bit hold_off);
      logic [63:0] va;
      logic [1:0]  mode;
      logic [3:0]  flags;
      write_seg_mask(mask);
      idle_pct  = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         // let the pipeline drain completely once in mid-stream
         if (hold_off && i == count / 2)
            wait_drained();
         random_item(va, mode, flags);
         send_item(va, mode, flags);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset mask, no idling
      send_item(64'h0000_0000_0000_0000, MODE_USER,       F_NONE);
      send_item(64'h0000_0000_7FFF_FFFF, MODE_USER,       F_ERL);
      send_item(64'h0000_0000_7FFF_FFFF, MODE_KERNEL,     F_NONE);
      send_item(64'h0000_0000_8000_0000, MODE_USER,       F_UX);
      send_item(SEG_MASK_RESET,          MODE_USER,       F_UX);
      send_item(SEG_MASK_RESET + 64'd1,  MODE_USER,       F_UX);
      send_item(64'h3FFF_FFFF_FFFF_FFFF, MODE_KERNEL,     4'hF);
      send_item(64'h4000_0000_0000_0000, MODE_SUPER,      F_SX);
      send_item(64'h4000_00FF_FFFF_FFFF, MODE_KERNEL,     F_SX);
      send_item(64'h4000_0100_0000_0000, MODE_SUPER,      F_SX);
      send_item(64'h4000_0000_0000_0000, MODE_USER,       F_X64);
      send_item(64'h8000_0000_0000_0000, MODE_KERNEL,     F_KX);
      send_item(64'hB800_000F_FFFF_FFFF, MODE_KERNEL,     F_KX);
      send_item(64'h8000_0010_0000_0000, MODE_KERNEL,     F_KX);
      send_item(64'hBFFF_FFFF_FFFF_FFFF, MODE_KERNEL,     F_X64);
      send_item(64'hC000_0000_0000_0000, MODE_KERNEL,     F_KX);
      send_item(64'hFFFF_FFFF_7FFF_FFFF, MODE_KERNEL,     F_KX);
      send_item(64'hC000_00FF_FFFF_FFFF, MODE_ALT_KERNEL, F_KX);
      send_item(64'hFFFF_FFFF_8000_0000, MODE_KERNEL,     F_ERL);
      send_item(64'hFFFF_FFFF_9FFF_FFFF, MODE_USER,       F_X64);
      send_item(64'hFFFF_FFFF_A000_0000, MODE_ALT_KERNEL, F_NONE);
      send_item(64'hFFFF_FFFF_BFFF_FFFF, MODE_SUPER,      F_NONE);
      send_item(64'hFFFF_FFFF_C000_0000, MODE_SUPER,      F_NONE);
      send_item(64'hFFFF_FFFF_DFFF_FFFF, MODE_USER,       F_X64);
      send_item(64'hFFFF_FFFF_E000_0000, MODE_SUPER,      F_X64);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, MODE_KERNEL,     4'hF);

      // random part over several mask settings and idling and stall mixes
      run_phase(SEG_MASK_RESET,          0,  0,  100, 1'b0);
      run_phase(64'hFFFF_FFFF_FFFF_FFFF, 79, 0,  100, 1'b1);
      run_phase(64'h0000_0000_0000_0000, 0,  79, 100, 1'b0);
      run_phase(64'h0000_0FFF_FFFF_FFFF, 25, 25, 100, 1'b0);
      run_phase({$urandom, $urandom},    0,  0,  100, 1'b0);
      run_phase(64'h3FFF_FFFF_FFFF_FFFF, 25, 25, 100, 1'b0);

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("virtual_segment_decoder: match");
      end else begin
         $display("virtual_segment_decoder: mismatch");
      end
      $finish;
   end

endmodule
